### rtl/ccc_pkg.sv
// Shared widths, constants and stage payload types for the circle collision pipeline.
`timescale 1ns / 1ps
package ccc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int ROOT_W     = DIFF_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int RAD_W      = COORD_WIDTH - 1;
   localparam int NORM_W     = FRAC_BITS + 2;
   localparam int QUO_W      = FRAC_BITS + 2;
   localparam int DV_W       = ROOT_W + 1;
   localparam int DIV_STAGES = FRAC_BITS + 2;

   localparam logic [COORD_WIDTH-1:0] DEPTH_MISS =
      COORD_WIDTH'(-(longint'(1) << FRAC_BITS));
   localparam logic [COORD_WIDTH-1:0] DEPTH_MAX =
      COORD_WIDTH'((longint'(1) << (COORD_WIDTH - 1)) - 1);
   localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(longint'(1) << FRAC_BITS);

   typedef struct packed {
      logic                   sx;
      logic                   sy;
      logic [DIFF_W-1:0]      mx;
      logic [DIFF_W-1:0]      my;
      logic [COORD_WIDTH-1:0] cx;
      logic [COORD_WIDTH-1:0] cy;
      logic [COORD_WIDTH-1:0] rsum;
   } side_type;

   typedef struct packed {
      logic                   hit;
      logic                   dzero;
      logic                   sx;
      logic                   sy;
      logic [COORD_WIDTH-1:0] cx;
      logic [COORD_WIDTH-1:0] cy;
      logic [COORD_WIDTH-1:0] depth;
   } tag_type;

endpackage

### rtl/ccc_if.sv
// Request and response channel interfaces for the circle collision block.
`timescale 1ns / 1ps
interface ccc_req_if import ccc_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic        [RAD_W-1:0]       a_radius;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic        [RAD_W-1:0]       b_radius;

   modport source (output valid, a_x, a_y, a_radius, b_x, b_y, b_radius, input ready);
   modport sink   (input valid, a_x, a_y, a_radius, b_x, b_y, b_radius, output ready);
endinterface

interface ccc_rsp_if import ccc_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] contact_x;
   logic signed [COORD_WIDTH-1:0] contact_y;
   logic signed [NORM_W-1:0]      normal_x;
   logic signed [NORM_W-1:0]      normal_y;
   logic signed [COORD_WIDTH-1:0] depth;

   modport source (output valid, hit, contact_x, contact_y, normal_x, normal_y, depth,
                   input ready);
   modport sink   (input valid, hit, contact_x, contact_y, normal_x, normal_y, depth,
                   output ready);
endinterface

### rtl/ccc_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
`timescale 1ns / 1ps
module ccc_sqrt import ccc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [SQ_W-1:0]   in_rad,
   input  side_type          in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   typedef struct packed {
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      side_type          side;
   } sq_type;

   sq_type              st_ff [ROOT_W];
   logic [ROOT_W-1:0]   v_ff;
   logic [ROOT_W-1:0]   en;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      sq_type            prev;
      sq_type            st_in;
      logic              prev_v;
      logic              next_en;
      logic [REM_W-1:0]  rem2;
      logic [REM_W-1:0]  trial;

      if (i == 0) begin : g_first
         always_comb begin
            prev.rad  = in_rad;
            prev.rem  = '0;
            prev.root = '0;
            prev.side = in_side;
         end
         assign prev_v = in_valid;
      end else begin : g_next
         assign prev   = st_ff[i-1];
         assign prev_v = v_ff[i-1];
      end

      if (i == ROOT_W - 1) begin : g_tail
         assign next_en = out_ready;
      end else begin : g_body
         assign next_en = en[i+1];
      end

      assign en[i] = !v_ff[i] || next_en;

      always_comb begin
         rem2      = {prev.rem[REM_W-3:0], prev.rad[SQ_W-1:SQ_W-2]};
         trial     = {prev.root, 2'b01};
         st_in     = prev;
         st_in.rad = prev.rad << 2;
         if (rem2 >= trial) begin
            st_in.rem  = rem2 - trial;
            st_in.root = {prev.root[ROOT_W-2:0], 1'b1};
         end else begin
            st_in.rem  = rem2;
            st_in.root = {prev.root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en[i]) begin
            v_ff[i] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            st_ff[i] <= st_in;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = st_ff[ROOT_W-1].root;
   assign out_side  = st_ff[ROOT_W-1].side;

`ifndef NO_ASSERTIONS
   // remainder of a finished root never exceeds twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ({1'b0, st_ff[ROOT_W-1].rem} <= {2'b00, st_ff[ROOT_W-1].root, 1'b0}))
      else $error("sqrt remainder out of range");
   // radicand fully consumed at the last stage
   a_rad_done: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (st_ff[ROOT_W-1].rad == '0))
      else $error("sqrt radicand not consumed");
`endif

endmodule

### rtl/ccc_div.sv
// Pipelined two-lane fractional divider producing rounded unit ratios.
`timescale 1ns / 1ps
module ccc_div import ccc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [ROOT_W-1:0] in_num_x,
   input  logic [ROOT_W-1:0] in_num_y,
   input  logic [ROOT_W-1:0] in_den,
   input  tag_type           in_tag,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [QUO_W-1:0]  out_q_x,
   output logic [QUO_W-1:0]  out_q_y,
   output tag_type           out_tag
);

   typedef struct packed {
      logic [DV_W-1:0]  r;
      logic [QUO_W-1:0] q;
   } lane_type;

   typedef struct packed {
      lane_type          lx;
      lane_type          ly;
      logic [ROOT_W-1:0] den;
      tag_type           tag;
   } dv_type;

   function automatic lane_type lane_step(input lane_type l, input logic [ROOT_W-1:0] den,
                                          input int idx);
      lane_type        o;
      logic [DV_W-1:0] r2;
      logic            ge;
      o = l;
      if (idx == 0) begin
         r2 = l.r;
      end else begin
         r2 = {l.r[DV_W-2:0], 1'b0};
      end
      ge  = (r2 >= {1'b0, den});
      o.r = ge ? (r2 - {1'b0, den}) : r2;
      if (idx == DIV_STAGES - 1) begin
         o.q = l.q + QUO_W'(ge);
      end else begin
         o.q = {l.q[QUO_W-2:0], ge};
      end
      return o;
   endfunction

   dv_type                st_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] v_ff;
   logic [DIV_STAGES-1:0] en;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      dv_type prev;
      dv_type st_in;
      logic   prev_v;
      logic   next_en;

      if (i == 0) begin : g_first
         always_comb begin
            prev.lx.r = {1'b0, in_num_x};
            prev.lx.q = '0;
            prev.ly.r = {1'b0, in_num_y};
            prev.ly.q = '0;
            prev.den  = in_den;
            prev.tag  = in_tag;
         end
         assign prev_v = in_valid;
      end else begin : g_next
         assign prev   = st_ff[i-1];
         assign prev_v = v_ff[i-1];
      end

      if (i == DIV_STAGES - 1) begin : g_tail
         assign next_en = out_ready;
      end else begin : g_body
         assign next_en = en[i+1];
      end

      assign en[i] = !v_ff[i] || next_en;

      always_comb begin
         st_in    = prev;
         st_in.lx = lane_step(prev.lx, prev.den, i);
         st_in.ly = lane_step(prev.ly, prev.den, i);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en[i]) begin
            v_ff[i] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            st_ff[i] <= st_in;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_q_x   = st_ff[DIV_STAGES-1].lx.q;
   assign out_q_y   = st_ff[DIV_STAGES-1].ly.q;
   assign out_tag   = st_ff[DIV_STAGES-1].tag;

`ifndef NO_ASSERTIONS
   // numerators never exceed the root, so ratios stay within one
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_tag.dzero) |-> (out_q_x <= UNIT_ONE && out_q_y <= UNIT_ONE))
      else $error("normal ratio above one");
`endif

endmodule

### rtl/circle_circle_collision.sv
// Top level: two-circle intersection test with contact, unit normal and depth.
// Pipeline from request beat to response beat: 3 front stages,
// 33 root stages of one root bit each, 1 compare stage, 18 divider stages, output register.
// Throughput: one pair per cycle while rsp.ready stays high; every stage holds its beat under backpressure.
// Reset: synchronous, active high; clears all stage valid bits, no pending beats.
`timescale 1ns / 1ps
module circle_circle_collision import ccc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ccc_req_if.sink   req,
   ccc_rsp_if.source rsp
);

   // stage A: differences, midpoints, radius sum
   side_type          a_ff;
   side_type          a_in;
   logic              a_v_ff;
   logic              a_en;
   // stage B: squares
   side_type          b_ff;
   logic [SQ_W-1:0]   b_sqx_ff;
   logic [SQ_W-1:0]   b_sqy_ff;
   logic [SQ_W-1:0]   b_sqx_in;
   logic [SQ_W-1:0]   b_sqy_in;
   logic              b_v_ff;
   logic              b_en;
   // stage C: squared distance
   side_type          c_ff;
   logic [SQ_W-1:0]   c_rad_ff;
   logic [SQ_W-1:0]   c_rad_in;
   logic              c_v_ff;
   logic              c_en;
   // root
   logic              sq_in_ready;
   logic              sq_out_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;
   // stage D: hit test and depth
   tag_type           d_tag_ff;
   tag_type           d_tag_in;
   logic [ROOT_W-1:0] d_mx_ff;
   logic [ROOT_W-1:0] d_my_ff;
   logic [ROOT_W-1:0] d_den_ff;
   logic              d_v_ff;
   logic              d_en;
   logic [ROOT_W-1:0] d_raw;
   // divider
   logic              dv_in_ready;
   logic              dv_out_valid;
   logic [QUO_W-1:0]  dv_q_x;
   logic [QUO_W-1:0]  dv_q_y;
   tag_type           dv_tag;
   // stage E: response register
   logic              e_v_ff;
   logic              e_en;
   logic              e_hit_ff;
   logic [COORD_WIDTH-1:0] e_cx_ff, e_cy_ff, e_depth_ff;
   logic [NORM_W-1:0] e_nx_ff, e_ny_ff;
   logic [NORM_W-1:0] e_nx_in, e_ny_in;

   logic signed [DIFF_W-1:0] dx, dy, sum_x, sum_y;

   assign a_en      = !a_v_ff || b_en;
   assign b_en      = !b_v_ff || c_en;
   assign c_en      = !c_v_ff || sq_in_ready;
   assign d_en      = !d_v_ff || dv_in_ready;
   assign e_en      = !e_v_ff || rsp.ready;
   assign req.ready = a_en;

   always_comb begin
      dx      = DIFF_W'(req.a_x) - DIFF_W'(req.b_x);
      dy      = DIFF_W'(req.a_y) - DIFF_W'(req.b_y);
      sum_x   = DIFF_W'(req.a_x) + DIFF_W'(req.b_x);
      sum_y   = DIFF_W'(req.a_y) + DIFF_W'(req.b_y);
      a_in.sx = dx[DIFF_W-1];
      a_in.sy = dy[DIFF_W-1];
      a_in.mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      a_in.my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      a_in.cx = sum_x[DIFF_W-1:1];
      a_in.cy = sum_y[DIFF_W-1:1];
      a_in.rsum = COORD_WIDTH'(req.a_radius) + COORD_WIDTH'(req.b_radius);
   end

   assign b_sqx_in = a_ff.mx * a_ff.mx;
   assign b_sqy_in = a_ff.my * a_ff.my;
   assign c_rad_in = b_sqx_ff + b_sqy_ff;

   always_comb begin
      d_raw          = {1'b0, sq_side.rsum} - sq_root;
      d_tag_in.hit   = (sq_root <= {1'b0, sq_side.rsum});
      d_tag_in.dzero = (sq_root == '0);
      d_tag_in.sx    = sq_side.sx;
      d_tag_in.sy    = sq_side.sy;
      d_tag_in.cx    = sq_side.cx;
      d_tag_in.cy    = sq_side.cy;
      d_tag_in.depth = (d_raw > ROOT_W'(DEPTH_MAX)) ? DEPTH_MAX : d_raw[COORD_WIDTH-1:0];
   end

   always_comb begin
      if (!dv_tag.hit || dv_tag.dzero) begin
         e_nx_in = '0;
         e_ny_in = '0;
      end else begin
         e_nx_in = dv_tag.sx ? NORM_W'(-dv_q_x) : NORM_W'(dv_q_x);
         e_ny_in = dv_tag.sy ? NORM_W'(-dv_q_y) : NORM_W'(dv_q_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else begin
         if (a_en) a_v_ff <= req.valid;
         if (b_en) b_v_ff <= a_v_ff;
         if (c_en) c_v_ff <= b_v_ff;
         if (d_en) d_v_ff <= sq_out_valid;
         if (e_en) e_v_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_ff <= a_in;
      end
      if (b_en) begin
         b_ff     <= a_ff;
         b_sqx_ff <= b_sqx_in;
         b_sqy_ff <= b_sqy_in;
      end
      if (c_en) begin
         c_ff     <= b_ff;
         c_rad_ff <= c_rad_in;
      end
      if (d_en) begin
         d_tag_ff <= d_tag_in;
         d_mx_ff  <= sq_side.mx;
         d_my_ff  <= sq_side.my;
         d_den_ff <= sq_root;
      end
      if (e_en) begin
         e_hit_ff   <= dv_tag.hit;
         e_cx_ff    <= dv_tag.hit ? dv_tag.cx : '0;
         e_cy_ff    <= dv_tag.hit ? dv_tag.cy : '0;
         e_depth_ff <= dv_tag.hit ? dv_tag.depth : DEPTH_MISS;
         e_nx_ff    <= e_nx_in;
         e_ny_ff    <= e_ny_in;
      end
   end

   ccc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_v_ff),
      .in_ready  (sq_in_ready),
      .in_rad    (c_rad_ff),
      .in_side   (c_ff),
      .out_valid (sq_out_valid),
      .out_ready (d_en),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   ccc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_v_ff),
      .in_ready  (dv_in_ready),
      .in_num_x  (d_mx_ff),
      .in_num_y  (d_my_ff),
      .in_den    (d_den_ff),
      .in_tag    (d_tag_ff),
      .out_valid (dv_out_valid),
      .out_ready (e_en),
      .out_q_x   (dv_q_x),
      .out_q_y   (dv_q_y),
      .out_tag   (dv_tag)
   );

   assign rsp.valid     = e_v_ff;
   assign rsp.hit       = e_hit_ff;
   assign rsp.contact_x = e_cx_ff;
   assign rsp.contact_y = e_cy_ff;
   assign rsp.normal_x  = e_nx_ff;
   assign rsp.normal_y  = e_ny_ff;
   assign rsp.depth     = e_depth_ff;

`ifndef NO_ASSERTIONS
   // a miss carries the no-collision depth and zero geometry
   a_miss_fmt: assert property (@(posedge clock) disable iff (reset)
      (e_v_ff && !e_hit_ff) |-> (e_depth_ff == DEPTH_MISS && e_nx_ff == '0 && e_ny_ff == '0
                                 && e_cx_ff == '0 && e_cy_ff == '0))
      else $error("miss response not cleared");
   // a hit never reports negative depth
   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      (e_v_ff && e_hit_ff) |-> !e_depth_ff[COORD_WIDTH-1])
      else $error("hit with negative depth");
`endif

endmodule

### tb/sv/tb_top.sv
// Testbench for circle_circle_collision: table-driven directed beats, random pairs, backpressure.
`timescale 1ns / 1ps
module tb_top import ccc_pkg::*;;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
      logic [RAD_W-1:0]              ra, rb;
   } pair_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] cx, cy;
      logic signed [NORM_W-1:0]      nx, ny;
      logic signed [COORD_WIDTH-1:0] depth;
   } verdict_type;

   typedef struct {
      pair_type    p;
      logic        known;
      verdict_type v;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccc_req_if req();
   ccc_rsp_if rsp();

   circle_circle_collision dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   verdict_type pending_verdicts[$];
   int          mismatches = 0;
   bit          stim_done  = 0;
   bit          hold_rsp   = 0;
   row_type     rows[$];

   function automatic logic [65:0] root_floor(logic [131:0] s);
      logic [65:0]  r;
      logic [131:0] t;
      r = '0;
      for (int b = 65; b >= 0; b--) begin
         t = {66'd0, r | (66'd1 << b)};
         if (t * t <= s) r = r | (66'd1 << b);
      end
      return r;
   endfunction

   function automatic logic [NORM_W-1:0] unit_comp(logic signed [65:0] diff,
                                                  logic [65:0] d);
      logic [65:0] mag, q, r;
      mag = diff < 0 ? -diff : diff;
      if (d == 0) return '0;
      q = 0;
      r = mag;
      if (r >= d) begin q = 1; r = r - d; end
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin r = r - d; q = q | 1; end
      end
      r = r << 1;
      if (r >= d) q = q + 1;
      if (diff < 0) q = -q;
      return q[NORM_W-1:0];
   endfunction

   function automatic verdict_type collide(pair_type p);
      verdict_type        v;
      logic signed [65:0] dx, dy, sx, sy;
      logic [65:0]        mx, my, d, rsum, dep;
      dx = 66'(p.ax) - 66'(p.bx);
      dy = 66'(p.ay) - 66'(p.by);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      d = root_floor(132'(mx) * 132'(mx) + 132'(my) * 132'(my));
      rsum = 66'(p.ra) + 66'(p.rb);
      v = '{default: '0};
      if (d <= rsum) begin
         dep = rsum - d;
         if (dep > 66'(DEPTH_MAX)) dep = 66'(DEPTH_MAX);
         sx = 66'(p.ax) + 66'(p.bx);
         sy = 66'(p.ay) + 66'(p.by);
         v.hit = 1'b1;
         v.cx = COORD_WIDTH'(sx >>> 1);
         v.cy = COORD_WIDTH'(sy >>> 1);
         v.nx = unit_comp(dx, d);
         v.ny = unit_comp(dy, d);
         v.depth = dep[COORD_WIDTH-1:0];
      end else begin
         v.depth = DEPTH_MISS;
      end
      return v;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] rnd_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return COORD_WIDTH'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return COORD_WIDTH'($signed($urandom_range(0, 400)) - 200) << FRAC_BITS;
         default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 8)
                                              : 32'h8000_0000 + $urandom_range(0, 8);
      endcase
   endfunction

   function automatic pair_type rnd_pair();
      pair_type p;
      logic [COORD_WIDTH-1:0] dx, dy;
      p.ax = rnd_coord();
      p.ay = rnd_coord();
      p.ra = $urandom_range(0, 3) == 0 ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 300) << 16);
      p.rb = $urandom_range(0, 3) == 0 ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 300) << 16);
      if ($urandom_range(0, 1)) begin
         // nearby partner so that hits are common
         dx = COORD_WIDTH'($signed($urandom_range(0, 800 << 16)) - (400 << 16));
         dy = COORD_WIDTH'($signed($urandom_range(0, 800 << 16)) - (400 << 16));
         p.bx = p.ax + dx;
         p.by = p.ay + dy;
      end else begin
         p.bx = rnd_coord();
         p.by = rnd_coord();
      end
      return p;
   endfunction

   function automatic void add_row(logic signed [31:0] ax, ay, logic [30:0] ra,
                                   logic signed [31:0] bx, by, logic [30:0] rb,
                                   logic known, verdict_type v);
      row_type r;
      r.p = '{ax: ax, ay: ay, ra: ra, bx: bx, by: by, rb: rb};
      r.known = known;
      r.v = v;
      rows = {rows, r};
   endfunction

   localparam verdict_type MISS = '{hit: 0, cx: 0, cy: 0, nx: 0, ny: 0, depth: DEPTH_MISS};
   localparam verdict_type ANY  = '{default: '0};

   // sender
   initial begin
      int          gap;
      pair_type    p;
      verdict_type exp_v;
      req.valid = 1'b0;
      req.a_x = '0; req.a_y = '0; req.a_radius = '0;
      req.b_x = '0; req.b_y = '0; req.b_radius = '0;
      // coincident centres, zero radii
      add_row(0, 0, 0, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0});
      // coincident, unit radii
      add_row(32'h10000, 32'h20000, 31'h10000, 32'h10000, 32'h20000, 31'h10000, 1,
              '{1, 32'h10000, 32'h20000, 0, 0, 32'h20000});
      // touching along x: normal +1.0, depth 0
      add_row(32'h20000, 0, 31'h10000, 0, 0, 31'h10000, 1,
              '{1, 32'h10000, 0, 18'h10000, 0, 0});
      // touching along -y
      add_row(0, -32'sh20000, 31'h10000, 0, 0, 31'h10000, 1,
              '{1, 0, -32'sh10000, 0, -18'sh10000, 0});
      // just apart
      add_row(32'h20001, 0, 31'h10000, 0, 0, 31'h10000, 1, MISS);
      add_row(32'h7fffffff, 32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 1, MISS);
      add_row(32'h80000000, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h80000000,
              31'h7fffffff, 1, '{1, 32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff});
      add_row(32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h7fffffff,
              31'h7fffffff, 0, ANY);
      add_row(32'h7fffffff, 0, 31'h7fffffff, 32'h80000000, 0, 31'h7fffffff, 0, ANY);
      add_row(-32'sh1, -32'sh3, 31'h5, 32'h0, 32'h0, 31'h0, 0, ANY);
      add_row(32'h30000, 32'h40000, 31'h30000, 0, 0, 31'h30000, 0, ANY);
      add_row(32'h12345, -32'sh54321, 31'h7fffffff, 32'h1, 32'h2, 31'h0, 0, ANY);
      add_row(32'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa, 32'haaaaaaaa, 32'h55555555,
              31'h55555555, 0, ANY);
      add_row(1, 1, 1, 0, 0, 0, 0, ANY);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < rows.size() + 850; i++) begin
         if (i < rows.size()) p = rows[i].p;
         else p = rnd_pair();
         exp_v = (i < rows.size() && rows[i].known) ? rows[i].v : collide(p);
         pending_verdicts = {pending_verdicts, exp_v};
         if (i < rows.size() && rows[i].known && rows[i].v != collide(p))
            $display("table row %0d disagrees with predictor", i);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (i > 300 && i < 450) gap = 0;
         if (gap > 0 && req.valid) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req.valid <= 1'b1;
         req.a_x <= p.ax; req.a_y <= p.ay; req.a_radius <= p.ra;
         req.b_x <= p.bx; req.b_y <= p.by; req.b_radius <= p.rb;
         @(posedge clock);
         while (!req.ready) @(posedge clock);
      end
      req.valid <= 1'b0;
      stim_done = 1;
   end

   // long receiver hold-off while the sender streams
   initial begin
      repeat (5) @(posedge clock);
      repeat (3000) @(posedge clock);
      hold_rsp = 1;
      repeat (400) @(posedge clock);
      hold_rsp = 0;
   end

   // receiver
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if ($urandom_range(0, 4) == 0) stall = 0;
         if (stall > 0 || hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at %0t", $time);
         end else begin
            e = pending_verdicts.pop_front();
            if (rsp.hit !== e.hit || rsp.contact_x !== e.cx || rsp.contact_y !== e.cy ||
                rsp.normal_x !== e.nx || rsp.normal_y !== e.ny || rsp.depth !== e.depth) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit=%0d c=(%0d,%0d) n=(%0d,%0d) depth=%0d  got hit=%0d c=(%0d,%0d) n=(%0d,%0d) depth=%0d",
                           e.hit, e.cx, e.cy, e.nx, e.ny, e.depth, rsp.hit, rsp.contact_x,
                           rsp.contact_y, rsp.normal_x, rsp.normal_y, rsp.depth);
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
